/* rtl/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lbl failed");
`endif

/* rtl/sps_pkg.sv */
// package: types, register indexes and helpers of the stripe shader
`timescale 1ns / 1ps
package sps_pkg;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    REG_EVEN_LIMIT = 3'd0,
    REG_PERIOD     = 3'd1,
    REG_EVEN_COLOR = 3'd2,
    REG_ODD_COLOR  = 3'd3,
    REG_Y_STEP     = 3'd4,
    REG_DEPTH_STEP = 3'd5,
    REG_PROJ_MODE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] depth;
    logic        proj;
  } job_t;

  function automatic logic [31:0] blend(input logic [8:0] a, input logic [31:0] c,
                                        input logic [31:0] d);
    logic [31:0] res;
    logic [16:0] ch;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      ch = 17'(c[8*k +: 8]) * 17'(a) + 17'(d[8*k +: 8]) * (17'd256 - 17'(a));
      res[8*k +: 8] = ch[15:8];
    end
    return res;
  endfunction
endpackage

/* rtl/stripe_pattern_pixel_shader_core.sv */
// top level of the stripe pattern pixel shader
`timescale 1ns / 1ps
// stripe pattern pixel shader
// input channel valid_i / stall_o carries one pixel request: new_span_i,
// start_y_i, start_depth_i; output channel valid_o / stall_i carries pixel_o
// requests enter a two-entry queue holding the pre-step coordinates
// the back end handles one request at a time; in projective mode with a
// nonzero depth it runs the bit-serial divider (48 steps), then always the
// bit-serial modulo (32 steps)
// a stalled result holds in the output register; the queue keeps filling
// reset clears accumulators, registers to defaults and empties the queue
// configuration writes use cfg_we_i, cfg_idx_i, cfg_data_i while idle
module stripe_pattern_pixel_shader_core import sps_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        new_span_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] start_depth_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] pixel_o
);
  logic [29:0] el_q;
  logic [30:0] per_q;
  logic [31:0] ec_q, oc_q, ys_q, zs_q;
  logic pm_q;
  logic jv, jt;
  job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q <= 30'h10000; per_q <= 31'h20000; ec_q <= 32'hffffffff;
      oc_q <= 32'hff000000; ys_q <= '0; zs_q <= '0; pm_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EVEN_LIMIT: el_q <= cfg_data_i[29:0];
        REG_PERIOD:     per_q <= cfg_data_i[30:0];
        REG_EVEN_COLOR: ec_q <= cfg_data_i;
        REG_ODD_COLOR:  oc_q <= cfg_data_i;
        REG_Y_STEP:     ys_q <= cfg_data_i;
        REG_DEPTH_STEP: zs_q <= cfg_data_i;
        REG_PROJ_MODE:  pm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sps_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .new_span_i, .start_y_i, .start_depth_i,
    .y_step_i(ys_q), .depth_step_i(zs_q), .proj_i(pm_q),
    .job_valid_o(jv), .job_take_i(jt), .job_o(job)
  );

  sps_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_take_o(jt), .job_i(job),
    .even_limit_i(el_q), .period_i(per_q), .even_color_i(ec_q), .odd_color_i(oc_q),
    .valid_o, .stall_i, .pixel_o
  );
endmodule

/* rtl/sps_front.sv */
// front: accumulators and request queue
`timescale 1ns / 1ps
module sps_front import sps_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        new_span_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] start_depth_i,
  input  logic [31:0] y_step_i,
  input  logic [31:0] depth_step_i,
  input  logic        proj_i,
  output logic        job_valid_o,
  input  logic        job_take_i,
  output job_t        job_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [31:0] y_q, y_d, z_q, z_d, y_cur, z_cur;
  job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic push, pop;

  assign stall_o = (cnt_q == (AW+1)'(Depth));
  assign push = valid_i && !stall_o;
  assign pop = job_take_i && job_valid_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o = mem_q[rp_q];
  assign y_cur = new_span_i ? start_y_i : y_q;
  assign z_cur = new_span_i ? start_depth_i : z_q;
  assign y_d = y_cur + y_step_i;
  assign z_d = z_cur + depth_step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= '0; z_q <= '0; wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) begin
        y_q <= y_d; z_q <= z_d;
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{y: y_cur, depth: z_cur, proj: proj_i};
  end
endmodule

/* rtl/sps_back.sv */
// back: serial divide, serial modulo, colour choice
`timescale 1ns / 1ps
module sps_back import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_take_o,
  input  job_t        job_i,
  input  logic [29:0] even_limit_i,
  input  logic [30:0] period_i,
  input  logic [31:0] even_color_i,
  input  logic [31:0] odd_color_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] pixel_o
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_DIV = 4'b0010, ST_MOD = 4'b0100, ST_OUT = 4'b1000
  } state_e;
  state_e st_q;
  logic [5:0] cnt_q;
  logic [47:0] num_q;
  logic [31:0] den_q;
  logic [32:0] rem_q;
  logic neg_q;
  logic [31:0] coord_q;
  logic [31:0] mag_q;
  logic [30:0] mrem_q;
  logic cneg_q;
  logic [31:0] pix_q;
  logic vld_q;

  logic [32:0] rsh, rsub;
  logic [31:0] msh, msub;
  logic [31:0] qv, coord_w;
  logic [30:0] pos;
  logic [15:0] row;
  logic [8:0] a;
  logic [31:0] px;

  assign job_take_o = (st_q == ST_IDLE);
  assign valid_o = vld_q;
  assign pixel_o = pix_q;

  assign rsh = {rem_q[31:0], num_q[47]};
  assign rsub = rsh - {1'b0, den_q};
  assign msh = {mrem_q, mag_q[31]};
  assign msub = msh - {1'b0, period_i};
  assign qv = neg_q ? -num_q[31:0] : num_q[31:0];

  always_comb begin
    if (cneg_q && mrem_q != '0) pos = period_i - mrem_q;
    else pos = mrem_q;
    if (period_i == '0) pos = '0;
    row = 16'(pos >> 16);
    a = 9'd1 + 9'(pos[15:8]);
    px = even_color_i;
    if (row == '0) px = blend(a, even_color_i, odd_color_i);
    if (pos >= 31'(even_limit_i)) begin
      px = odd_color_i;
      if (row == 16'(even_limit_i >> 16)) px = blend(a, odd_color_i, even_color_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; vld_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (st_q == ST_OUT && (!vld_q || !stall_i)) vld_q <= 1'b1;
      else if (vld_q && !stall_i) vld_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            if (job_i.proj && job_i.depth != '0) begin
              st_q <= ST_DIV; cnt_q <= 6'd48;
            end else begin
              st_q <= ST_MOD; cnt_q <= 6'd33;
            end
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd1) begin
            st_q <= ST_MOD; cnt_q <= 6'd33;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_MOD: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!vld_q || !stall_i) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign coord_w = (st_q == ST_DIV) ? qv : coord_q;

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        num_q <= {(job_i.y[31] ? -job_i.y : job_i.y), 16'h0};
        den_q <= job_i.depth[31] ? -job_i.depth : job_i.depth;
        neg_q <= job_i.y[31] ^ job_i.depth[31];
        rem_q <= '0;
        coord_q <= (job_i.proj) ? 32'h0 : job_i.y;
        mag_q <= job_i.y[31] ? -job_i.y : job_i.y;
        cneg_q <= job_i.y[31];
        mrem_q <= '0;
      end
      ST_DIV: begin
        if (!rsub[32]) begin
          rem_q <= rsub; num_q <= {num_q[46:0], 1'b1};
        end else begin
          rem_q <= rsh; num_q <= {num_q[46:0], 1'b0};
        end
        if (cnt_q == 6'd1) begin
          coord_q <= neg_q ? -{num_q[30:0], !rsub[32]} : {num_q[30:0], !rsub[32]};
          mag_q <= (neg_q ? -{num_q[30:0], !rsub[32]} : {num_q[30:0], !rsub[32]});
        end
      end
      ST_MOD: begin
        if (cnt_q == 6'd33) begin
          cneg_q <= coord_w[31];
          mag_q <= coord_w[31] ? -coord_w : coord_w;
          mrem_q <= '0;
        end else begin
          mag_q <= {mag_q[30:0], 1'b0};
          mrem_q <= (!msub[31] && period_i != '0) ? msub[30:0] : msh[30:0];
        end
      end
      ST_OUT: if (!vld_q || !stall_i) pix_q <= px;
      default: ;
    endcase
  end
endmodule

/* rtl/sps_checker.sv */
// port checker for the stripe shader, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] pixel_o,
  input logic        valid_i,
  input logic        stall_o
);
  `CHK_ASSERT(a_hold_valid, clk_i, rst_ni, valid_o && stall_i |=> valid_o)
  `CHK_ASSERT(a_hold_pixel, clk_i, rst_ni, valid_o && stall_i |=> $stable(pixel_o))
  `CHK_ASSERT(a_no_early, clk_i, rst_ni, $past(!rst_ni) |-> !valid_o)
  `CHK_ASSERT(a_hold_req, clk_i, rst_ni, valid_i && stall_o |=> valid_i)
endmodule

bind stripe_pattern_pixel_shader_core sps_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .pixel_o, .valid_i, .stall_o
);

/* dv/stripe_pattern_pixel_shader_checker.sv */
`timescale 1ns / 1ps
// checker: predicts stripe pixels from observed requests and compares the results
module stripe_pattern_pixel_shader_checker import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic        new_span_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] start_depth_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [31:0] pixel_o,
  output int          errors_o,
  output int          pending_o
);
  logic [29:0] even_limit_q;
  logic [30:0] period_q;
  logic [31:0] even_color_q, odd_color_q, y_step_q, depth_step_q;
  logic        proj_q;
  logic [31:0] y_acc, depth_acc;
  logic [31:0] expected_pixels[$];

  function automatic logic [31:0] mix_colours(logic [8:0] a, logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    int unsigned ch;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      ch = c[8*k +: 8] * a + d[8*k +: 8] * (256 - a);
      res[8*k +: 8] = ch[15:8];
    end
    return res;
  endfunction

  function automatic logic [31:0] stripe_colour(logic [31:0] y, logic [31:0] z);
    longint coord, pos, per, q, yy, zz;
    logic [63:0] qbits, pbits;
    logic [8:0] a;
    logic [31:0] px;
    yy = longint'($signed(y));
    zz = longint'($signed(z));
    if (proj_q) begin
      if (zz == 0) begin
        coord = 0;
      end else begin
        q = (yy * 65536) / zz;
        qbits = q;
        coord = longint'($signed(qbits[31:0]));
      end
    end else begin
      coord = yy;
    end
    per = longint'({33'd0, period_q});
    if (per == 0) begin
      pos = 0;
    end else begin
      pos = coord % per;
      if (pos < 0) pos = pos + per;
    end
    pbits = pos;
    a = 9'd1 + 9'(pbits[15:8]);
    px = even_color_q;
    if (pbits[63:16] == 0) px = mix_colours(a, even_color_q, odd_color_q);
    if (pos >= longint'({34'd0, even_limit_q})) begin
      px = odd_color_q;
      if (pbits[63:16] == 48'(even_limit_q[29:16]))
        px = mix_colours(a, odd_color_q, even_color_q);
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] y, z, got, want;
    if (!rst_ni) begin
      even_limit_q <= 30'h10000;
      period_q <= 31'h20000;
      even_color_q <= 32'hffffffff;
      odd_color_q <= 32'hff000000;
      y_step_q <= '0;
      depth_step_q <= '0;
      proj_q <= 1'b0;
      y_acc <= '0;
      depth_acc <= '0;
      expected_pixels.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EVEN_LIMIT: even_limit_q <= cfg_data_i[29:0];
          REG_PERIOD:     period_q <= cfg_data_i[30:0];
          REG_EVEN_COLOR: even_color_q <= cfg_data_i;
          REG_ODD_COLOR:  odd_color_q <= cfg_data_i;
          REG_Y_STEP:     y_step_q <= cfg_data_i;
          REG_DEPTH_STEP: depth_step_q <= cfg_data_i;
          REG_PROJ_MODE:  proj_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (valid_i && !stall_o) begin
        y = new_span_i ? start_y_i : y_acc;
        z = new_span_i ? start_depth_i : depth_acc;
        expected_pixels.push_back(stripe_colour(y, z));
        y_acc <= y + y_step_q;
        depth_acc <= z + depth_step_q;
      end
      if (valid_o && !stall_i) begin
        got = pixel_o;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            $display("%0t: pixel mismatch, expected %h, actual %h", $time, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_pixels.size();
    end
  end
endmodule

/* dv/tb_stripe_pattern_pixel_shader_core.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, request and configuration stimulus, verdict
module tb_stripe_pattern_pixel_shader_core;
  import sps_pkg::*;

  localparam logic [2:0] UnusedIdx = 3'd7;
  localparam int CycleLimit = 1500000;

  logic clk_i, rst_ni, cfg_we_i, valid_i, stall_o, new_span_i, valid_o, stall_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i, start_y_i, start_depth_i, pixel_o;
  int errors, pending, cycles;
  bit sender_busy_mode, receiver_busy_mode;

  stripe_pattern_pixel_shader_core uut (.*);

  stripe_pattern_pixel_shader_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i, .stall_o,
    .new_span_i, .start_y_i, .start_depth_i, .valid_o, .stall_i, .pixel_o,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // receiver back-pressure
  initial begin
    int n;
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_busy_mode && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        stall_i = 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_pixel(logic span, logic [31:0] y, logic [31:0] z);
    int n;
    n = sender_busy_mode ? gap_len() : 0;
    repeat (n) @(negedge clk_i);
    valid_i = 1'b1;
    new_span_i = span;
    start_y_i = y;
    start_depth_i = z;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
    valid_i = 1'b0;
    new_span_i = $urandom_range(0, 1);
    start_y_i = $urandom;
    start_depth_i = $urandom;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
    endcase
  endfunction

  task automatic random_setup();
    case ($urandom_range(0, 4))
      0: write_reg(REG_EVEN_LIMIT, 32'd65535);
      1: write_reg(REG_EVEN_LIMIT, 32'h3fffffff);
      2: write_reg(REG_EVEN_LIMIT, $urandom);
      default: write_reg(REG_EVEN_LIMIT, $urandom_range(0, 32'h60000));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_PERIOD, 32'd131070);
      1: write_reg(REG_PERIOD, 32'h7fffffff);
      2: write_reg(REG_PERIOD, $urandom);
      3: write_reg(REG_PERIOD, 32'd0);
      default: write_reg(REG_PERIOD, $urandom_range(32'h10000, 32'h80000));
    endcase
    write_reg(REG_EVEN_COLOR, $urandom);
    write_reg(REG_ODD_COLOR, $urandom);
    write_reg(REG_Y_STEP, pick_step());
    write_reg(REG_DEPTH_STEP, pick_step());
    write_reg(REG_PROJ_MODE, $urandom);
    if ($urandom_range(0, 3) == 0) write_reg(UnusedIdx, $urandom);
  endtask

  initial begin
    logic [31:0] y, z;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_EVEN_LIMIT;
    cfg_data_i = '0;
    valid_i = 1'b0;
    new_span_i = 1'b0;
    start_y_i = '0;
    start_depth_i = '0;
    sender_busy_mode = 1'b0;
    receiver_busy_mode = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // affine extremes with reset settings
    send_pixel(1'b1, 32'h0, 32'h0);
    send_pixel(1'b1, 32'hffffffff, 32'hffffffff);
    send_pixel(1'b1, 32'h7fffffff, 32'h7fffffff);
    send_pixel(1'b1, 32'h80000000, 32'h80000000);
    send_pixel(1'b1, 32'h00018000, 32'h1);
    send_pixel(1'b0, 32'h0, 32'h0);
    drain();
    // projective: zero depth, negative depth, overflowing quotient
    write_reg(REG_PROJ_MODE, 32'd1);
    write_reg(REG_Y_STEP, 32'h00004000);
    write_reg(REG_DEPTH_STEP, 32'hffffffff);
    write_reg(UnusedIdx, 32'hffffffff);
    send_pixel(1'b1, 32'h00030000, 32'h0);
    send_pixel(1'b1, 32'h80000000, 32'hffffffff);
    send_pixel(1'b1, 32'h7fffffff, 32'h1);
    send_pixel(1'b1, 32'h00050000, 32'h80000000);
    send_pixel(1'b0, 32'h0, 32'h0);
    send_pixel(1'b1, 32'h12345678, 32'h7fffffff);
    drain();
    // zero period and thin even stripe
    write_reg(REG_PROJ_MODE, 32'd0);
    write_reg(REG_PERIOD, 32'd0);
    send_pixel(1'b1, 32'h00028000, 32'h0);
    send_pixel(1'b0, 32'h0, 32'h0);
    drain();
    write_reg(REG_PERIOD, 32'd131070);
    write_reg(REG_EVEN_LIMIT, 32'h00008000);
    write_reg(REG_EVEN_COLOR, 32'h00ff00ff);
    write_reg(REG_ODD_COLOR, 32'hff00ff00);
    send_pixel(1'b1, 32'h00004000, 32'h0);
    send_pixel(1'b1, 32'h0000c000, 32'h0);
    send_pixel(1'b1, 32'h0001ffff, 32'h0);
    drain();
    write_reg(REG_EVEN_LIMIT, 32'h3fffffff);
    write_reg(REG_PERIOD, 32'h7fffffff);
    send_pixel(1'b1, 32'h7fffffff, 32'h0);
    send_pixel(1'b1, 32'h80000000, 32'h0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      sender_busy_mode = (ph % 3) != 2;
      receiver_busy_mode = (ph % 4) != 3;
      for (int i = 0; i < 85; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          y = $urandom;
          z = $urandom;
        end else begin
          y = 32'($signed($urandom_range(0, 32'h100000)) - 32'sh80000);
          z = $urandom_range(0, 3) == 0 ? 32'h0 : 32'h10000 + $urandom_range(0, 32'h40000);
        end
        send_pixel($urandom_range(0, 5) == 0 || i == 0, y, z);
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/stripe_pattern_pixel_shader_core.sv
rtl/sps_checker.sv
dv/stripe_pattern_pixel_shader_checker.sv
dv/tb_stripe_pattern_pixel_shader_core.sv
